>>> sv/frw_pkg.sv
package frw_pkg;

    // max_window register width and reset value
    localparam int MAXW_BITS = 24;
    localparam logic [MAXW_BITS-1:0] MAXW_RESET = 24'd131072;

    // per-item status bits handed from the core to the output register
    typedef struct packed {
        logic issue;
        logic ra_off;
    } t_rsp_ctl;

endpackage

>>> sv/frw_if.sv
// request channel: one read request per item
interface frw_req_if #(
    parameter int OFFSET_BITS = 48,
    parameter int LENGTH_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] req_offset;
    logic [LENGTH_BITS-1:0] req_length;

    modport source (output valid, output req_offset, output req_length, input ready);
    modport sink   (input valid, input req_offset, input req_length, output ready);
endinterface

// result channel: one prefetch decision per item
interface frw_rsp_if #(
    parameter int OFFSET_BITS = 48,
    parameter int LENGTH_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic                   issue;
    logic [OFFSET_BITS-1:0] prefetch_start;
    logic [LENGTH_BITS-1:0] prefetch_length;
    logic                   ra_off;

    modport source (output valid, output issue, output prefetch_start,
                    output prefetch_length, output ra_off, input ready);
    modport sink   (input valid, input issue, input prefetch_start,
                    input prefetch_length, input ra_off, output ready);
endinterface

>>> sv/file_readahead_window_unit.sv
// Sequential read-ahead window tracker. Each request item (byte offset, length)
// yields one result item: whether a prefetch is issued, its start and length,
// and whether read-ahead has been switched off by repeated misses. A request
// is registered on input, evaluated against the current and ahead windows,
// and its result lands in an output register, so one item is taken every
// cycle while the result side is not stalled. The output register lets the
// next request enter while a result waits. max_window (reset 131072) is to be
// written through i_cfg_we/i_cfg_wdata only while the block is idle; the block
// itself does not enforce this. A zero max_window makes every request a no-op.
// Window offsets saturate at the top of the offset range instead of wrapping.
module file_readahead_window_unit
    import frw_pkg::*;
#(
    parameter int OFFSET_BITS = 48,
    parameter int LENGTH_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    frw_req_if.sink              i_req,
    frw_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [MAXW_BITS-1:0] i_cfg_wdata
);

    logic                   in_valid;
    logic [OFFSET_BITS-1:0] in_offset;
    logic [LENGTH_BITS-1:0] in_length;
    logic                   out_space;
    logic                   advance;
    t_rsp_ctl               core_ctl;
    logic [OFFSET_BITS-1:0] core_start;
    logic [LENGTH_BITS-1:0] core_length;

    // the held request is processed when the output register can take it
    assign advance = in_valid && out_space;

    frw_in_reg #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_offset  (in_offset),
        .o_length  (in_length)
    );

    frw_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (advance),
        .i_offset    (in_offset),
        .i_length    (in_length),
        .o_ctl       (core_ctl),
        .o_start     (core_start),
        .o_length    (core_length)
    );

    frw_out_reg #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_ctl    (core_ctl),
        .i_start  (core_start),
        .i_length (core_length),
        .o_space  (out_space),
        .o_rsp    (o_rsp)
    );

endmodule

>>> sv/frw_in_reg.sv
module frw_in_reg
    import frw_pkg::*;
#(
    parameter int OFFSET_BITS = 48,
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    frw_req_if.sink                i_req,
    input  logic                   i_advance,
    output logic                   o_valid,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [LENGTH_BITS-1:0] o_length
);

    logic                   r_valid;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [LENGTH_BITS-1:0] r_length;
    logic                   load;

    // take a new item when empty or when the held item moves on this cycle
    assign i_req.ready = !r_valid || i_advance;
    assign load        = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_offset <= i_req.req_offset;
            r_length <= i_req.req_length;
        end
    end

    assign o_valid  = r_valid;
    assign o_offset = r_offset;
    assign o_length = r_length;

endmodule

>>> sv/frw_core.sv
module frw_core
    import frw_pkg::*;
#(
    parameter int OFFSET_BITS = 48,
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [MAXW_BITS-1:0]   i_cfg_wdata,
    input  logic                   i_step,
    input  logic [OFFSET_BITS-1:0] i_offset,
    input  logic [LENGTH_BITS-1:0] i_length,
    output t_rsp_ctl               o_ctl,
    output logic [OFFSET_BITS-1:0] o_start,
    output logic [LENGTH_BITS-1:0] o_length
);

    // width one bit wider than the larger of window size and twice a request length
    localparam int SUM_BITS = ((MAXW_BITS > LENGTH_BITS + 1) ? MAXW_BITS : LENGTH_BITS + 1) + 1;

    // saturating offset add
    function automatic logic [OFFSET_BITS-1:0] sat_add(
        input logic [OFFSET_BITS-1:0] a,
        input logic [LENGTH_BITS-1:0] b
    );
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + {{(OFFSET_BITS + 1 - LENGTH_BITS){1'b0}}, b};
        return s[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : s[OFFSET_BITS-1:0];
    endfunction

    logic [MAXW_BITS-1:0]   r_maxw;
    logic [MAXW_BITS-1:0]   r_nw, n_nw;
    logic [OFFSET_BITS-1:0] r_ws, n_ws;
    logic [LENGTH_BITS-1:0] r_wl, n_wl;
    logic [OFFSET_BITS-1:0] r_as, n_as;
    logic [LENGTH_BITS-1:0] r_al, n_al;
    logic                   r_dis, n_dis;

    logic [OFFSET_BITS-1:0] off_delta;
    logic                   off_ge_ws;
    logic                   hit;
    logic                   in_win;
    logic [OFFSET_BITS-1:0] req_end;
    logic [OFFSET_BITS-1:0] win_end;
    logic [SUM_BITS-1:0]    nw_ext;
    logic [SUM_BITS-1:0]    len2;
    logic [SUM_BITS-1:0]    maxw_ext;
    logic [SUM_BITS-1:0]    up;
    logic [SUM_BITS-1:0]    dn;
    logic                   kill;
    logic [MAXW_BITS-1:0]   nw_upd;
    logic [SUM_BITS-1:0]    upd_ext;
    logic [SUM_BITS-1:0]    n_nw_ext;
    logic                   restart;
    logic [OFFSET_BITS-1:0] as_eff;
    logic [LENGTH_BITS-1:0] al_eff;
    logic                   issue;
    logic [OFFSET_BITS-1:0] p_start;
    logic [LENGTH_BITS-1:0] p_len;

    // window position tests
    assign off_ge_ws = i_offset >= r_ws;
    assign off_delta = i_offset - r_ws;
    assign hit       = off_ge_ws && (off_delta <= {{(OFFSET_BITS - LENGTH_BITS){1'b0}}, r_wl});
    assign in_win    = off_ge_ws && (off_delta < {{(OFFSET_BITS - LENGTH_BITS){1'b0}}, r_wl});
    assign req_end   = sat_add(i_offset, i_length);
    assign win_end   = sat_add(r_ws, r_wl);

    // window size update: grow on hit, shrink on miss, clamp to max
    assign nw_ext   = {{(SUM_BITS - MAXW_BITS){1'b0}}, r_nw};
    assign len2     = {{(SUM_BITS - LENGTH_BITS - 1){1'b0}}, i_length, 1'b0};
    assign maxw_ext = {{(SUM_BITS - MAXW_BITS){1'b0}}, r_maxw};
    assign up       = nw_ext + len2;
    assign dn       = nw_ext - len2;
    assign kill     = !hit && (len2 >= nw_ext);

    always_comb begin
        if (hit) begin
            nw_upd = (up > maxw_ext) ? r_maxw : up[MAXW_BITS-1:0];
        end else begin
            nw_upd = (dn > maxw_ext) ? r_maxw : dn[MAXW_BITS-1:0];
        end
    end

    assign upd_ext = {{(SUM_BITS - MAXW_BITS){1'b0}}, nw_upd};

    // next state and result
    always_comb begin
        n_nw    = r_nw;
        n_ws    = r_ws;
        n_wl    = r_wl;
        n_as    = r_as;
        n_al    = r_al;
        n_dis   = r_dis;
        restart = 1'b0;
        issue   = 1'b0;
        p_start = '0;
        p_len   = '0;
        as_eff  = r_as;
        al_eff  = r_al;
        if (!r_dis && (r_maxw != '0)) begin
            if (r_nw == '0) begin
                // first request
                n_nw    = r_maxw >> 1;
                restart = 1'b1;
            end else if (kill) begin
                n_nw  = '0;
                n_dis = 1'b1;
                n_wl  = '0;
            end else begin
                n_nw = nw_upd;
                if (!in_win) begin
                    restart = 1'b1;
                end else begin
                    // issue the ahead window once
                    if (r_as == '0) begin
                        as_eff  = win_end;
                        al_eff  = upd_ext[LENGTH_BITS-1:0];
                        n_as    = as_eff;
                        n_al    = al_eff;
                        issue   = 1'b1;
                        p_start = as_eff;
                        p_len   = al_eff;
                    end
                    // request reaches the ahead window: promote it
                    if (req_end >= as_eff) begin
                        n_ws = req_end;
                        n_wl = al_eff;
                        n_as = '0;
                        n_al = '0;
                    end
                end
            end
        end
        n_nw_ext = {{(SUM_BITS - MAXW_BITS){1'b0}}, n_nw};
        if (restart) begin
            n_ws    = i_offset;
            n_wl    = n_nw_ext[LENGTH_BITS-1:0];
            n_as    = '0;
            n_al    = '0;
            issue   = 1'b1;
            p_start = i_offset;
            p_len   = n_nw_ext[LENGTH_BITS-1:0];
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxw <= MAXW_RESET;
        end else if (i_cfg_we) begin
            r_maxw <= i_cfg_wdata;
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nw  <= '0;
            r_ws  <= '0;
            r_wl  <= '0;
            r_as  <= '0;
            r_al  <= '0;
            r_dis <= 1'b0;
        end else if (i_step) begin
            r_nw  <= n_nw;
            r_ws  <= n_ws;
            r_wl  <= n_wl;
            r_as  <= n_as;
            r_al  <= n_al;
            r_dis <= n_dis;
        end
    end

    assign o_ctl.issue  = issue;
    assign o_ctl.ra_off = n_dis;
    assign o_start      = p_start;
    assign o_length     = p_len;

endmodule

>>> sv/frw_out_reg.sv
module frw_out_reg
    import frw_pkg::*;
#(
    parameter int OFFSET_BITS = 48,
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_rsp_ctl               i_ctl,
    input  logic [OFFSET_BITS-1:0] i_start,
    input  logic [LENGTH_BITS-1:0] i_length,
    output logic                   o_space,
    frw_rsp_if.source              o_rsp
);

    logic                   r_valid;
    t_rsp_ctl               r_ctl;
    logic [OFFSET_BITS-1:0] r_start;
    logic [LENGTH_BITS-1:0] r_length;

    // room for a new result when empty or being drained
    assign o_space = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl    <= i_ctl;
            r_start  <= i_start;
            r_length <= i_length;
        end
    end

    assign o_rsp.valid           = r_valid;
    assign o_rsp.issue           = r_ctl.issue;
    assign o_rsp.ra_off          = r_ctl.ra_off;
    assign o_rsp.prefetch_start  = r_start;
    assign o_rsp.prefetch_length = r_length;

endmodule

>>> test/frw_window_checker.sv
// Watches the request, result and config ports of the read-ahead window unit,
// predicts one result item per accepted request and compares in order.
module frw_window_checker
    import frw_pkg::*;
#(
    parameter int OFFSET_BITS = 48,
    parameter int LENGTH_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [MAXW_BITS-1:0] i_cfg_wdata,
    frw_req_if                   i_req_mon,
    frw_rsp_if                   i_rsp_mon,
    output int                   o_mismatch_count,
    output int                   o_pending
);

    localparam logic [63:0] OFF_TOP  = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam logic [63:0] LEN_MASK = (64'd1 << LENGTH_BITS) - 64'd1;

    typedef struct packed {
        logic                   issue;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] length;
        logic                   ra_off;
    } t_prefetch;

    // mirrored window state
    logic [63:0] max_win;
    longint      win_budget;    // size of the next prefetch, 0 before first request
    logic [63:0] cur_start;
    logic [63:0] cur_len;
    logic [63:0] ahd_start;     // 0 means no ahead window
    logic [63:0] ahd_len;
    bit          ra_disabled;

    t_prefetch   prefetch_q[$];
    int          mismatches;
    int          results_seen;

    // offset sums clip at the top of the offset range
    function automatic logic [63:0] clip_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, OFF_TOP})
            return OFF_TOP;
        return s[63:0];
    endfunction

    // one request through the window rules; updates the mirrored state
    function automatic t_prefetch next_prefetch(logic [63:0] off, logic [63:0] len);
        t_prefetch r;
        bit        hit;
        bit        restart;
        longint    delta;
        r       = '0;
        restart = 1'b0;
        if (!ra_disabled && max_win != 0) begin
            if (win_budget == 0) begin
                // first request: half the largest window
                win_budget = longint'(max_win >> 1);
                restart    = 1'b1;
            end else begin
                hit   = off >= cur_start && (off - cur_start) <= cur_len;
                delta = 2 * longint'(len);
                win_budget = hit ? win_budget + delta : win_budget - delta;
                if (win_budget > longint'(max_win))
                    win_budget = longint'(max_win);
                if (win_budget <= 0) begin
                    // too many misses: read-ahead off for good
                    win_budget  = 0;
                    ra_disabled = 1'b1;
                    cur_len     = '0;
                end else begin
                    restart = off < cur_start || (off - cur_start) >= cur_len;
                    if (!restart) begin
                        if (ahd_start == 0) begin
                            ahd_start = clip_sum(cur_start, cur_len);
                            ahd_len   = 64'(win_budget) & LEN_MASK;
                            r.issue   = 1'b1;
                            r.start   = ahd_start[OFFSET_BITS-1:0];
                            r.length  = ahd_len[LENGTH_BITS-1:0];
                        end
                        // request reached the ahead window: promote it
                        if (off >= ahd_start || (ahd_start - off) <= len) begin
                            cur_start = clip_sum(off, len);
                            cur_len   = ahd_len;
                            ahd_start = '0;
                            ahd_len   = '0;
                        end
                    end
                end
            end
            if (restart) begin
                cur_start = off;
                cur_len   = 64'(win_budget) & LEN_MASK;
                ahd_start = '0;
                ahd_len   = '0;
                r.issue   = 1'b1;
                r.start   = off[OFFSET_BITS-1:0];
                r.length  = cur_len[LENGTH_BITS-1:0];
            end
        end
        r.ra_off = ra_disabled;
        return r;
    endfunction

    // sample all ports at the clock edge
    always @(posedge i_clk) begin
        t_prefetch seen;
        t_prefetch want;
        if (!i_rst_n) begin
            max_win     = 64'(MAXW_RESET);
            win_budget  = 0;
            cur_start   = '0;
            cur_len     = '0;
            ahd_start   = '0;
            ahd_len     = '0;
            ra_disabled = 1'b0;
            prefetch_q.delete();
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (i_cfg_we)
                max_win = 64'(i_cfg_wdata);
            if (i_req_mon.valid && i_req_mon.ready)
                prefetch_q.push_back(next_prefetch(64'(i_req_mon.req_offset),
                                                   64'(i_req_mon.req_length)));
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                seen.issue  = i_rsp_mon.issue;
                seen.start  = i_rsp_mon.prefetch_start;
                seen.length = i_rsp_mon.prefetch_length;
                seen.ra_off = i_rsp_mon.ra_off;
                if (prefetch_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d with nothing expected: ",
                                  "issue=%0b start=%h len=%h ra_off=%0b"},
                                 results_seen, seen.issue, seen.start, seen.length,
                                 seen.ra_off);
                end else begin
                    want = prefetch_q.pop_front();
                    if (seen.issue !== want.issue || seen.start !== want.start ||
                        seen.length !== want.length || seen.ra_off !== want.ra_off) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d mismatch", results_seen);
                            $display("  expected issue=%0b start=%h len=%h ra_off=%0b",
                                     want.issue, want.start, want.length, want.ra_off);
                            $display("  actual   issue=%0b start=%h len=%h ra_off=%0b",
                                     seen.issue, seen.start, seen.length, seen.ra_off);
                        end
                    end
                end
                results_seen++;
            end
        end
        o_pending        <= prefetch_q.size();
        o_mismatch_count <= mismatches;
    end

endmodule

>>> test/tb.sv
module tb;
    import frw_pkg::*;

    localparam int OB = 48;
    localparam int LB = 24;
    localparam logic [OB-1:0] OFF_TOP = '1;
    localparam logic [LB-1:0] LEN_TOP = '1;
    localparam logic [MAXW_BITS-1:0] MAXW_TOP = '1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [MAXW_BITS-1:0] cfg_wdata = '0;

    int mismatches;
    int outstanding;

    // stimulus controls
    bit                   gaps_on = 1'b0;
    bit                   stalls_on = 1'b0;
    int                   stall_left = 0;
    int                   live_items = 0;
    logic [OB-1:0]        stream_pos = '0;
    logic [MAXW_BITS-1:0] cur_maxw = MAXW_RESET;

    frw_req_if #(.OFFSET_BITS(OB), .LENGTH_BITS(LB)) req_ch ();
    frw_rsp_if #(.OFFSET_BITS(OB), .LENGTH_BITS(LB)) rsp_ch ();

    file_readahead_window_unit #(.OFFSET_BITS(OB), .LENGTH_BITS(LB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    frw_window_checker #(.OFFSET_BITS(OB), .LENGTH_BITS(LB)) chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_req_mon        (req_ch),
        .i_rsp_mon        (rsp_ch),
        .o_mismatch_count (mismatches),
        .o_pending        (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 8);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // present one request item and hold it until accepted
    task automatic send_req(logic [OB-1:0] off, logic [LB-1:0] len);
        logic [OB:0] span_end;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_offset <= off;
        req_ch.req_length <= len;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        span_end   = {1'b0, off} + (OB + 1)'(len);
        stream_pos = span_end[OB] ? OFF_TOP : span_end[OB-1:0];
        if (cur_maxw != 0)
            live_items++;
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_max_window(logic [MAXW_BITS-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_maxw   = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly sequential reads with re-reads, far jumps and reads near the top
    task automatic random_stream(int count);
        logic [LB-1:0] lim;
        logic [LB-1:0] miss_lim;
        logic [OB-1:0] off;
        logic [LB-1:0] len;
        int            sel;
        int            back;
        for (int i = 0; i < count; i++) begin
            lim      = (cur_maxw >> 3) == 0 ? LB'(1) : LB'(cur_maxw >> 3);
            miss_lim = LB'(cur_maxw >> 7);
            sel      = $urandom_range(0, 99);
            if (sel < 70) begin
                off = stream_pos;
                len = (sel < 2) ? LB'($urandom()) : LB'($urandom_range(0, lim));
            end else if (sel < 80) begin
                back = $urandom_range(0, lim);
                off  = (stream_pos > OB'(back)) ? stream_pos - OB'(back) : '0;
                len  = LB'($urandom_range(0, lim));
            end else if (sel < 92) begin
                off = OB'({$urandom(), $urandom()});
                len = LB'($urandom_range(0, miss_lim));
            end else begin
                off = OFF_TOP - OB'($urandom_range(0, 4 * lim));
                len = LB'($urandom_range(0, miss_lim));
            end
            send_req(off, len);
        end
    endtask

    initial begin
        logic [MAXW_BITS-1:0] new_maxw;
        req_ch.valid      = 1'b0;
        req_ch.req_offset = '0;
        req_ch.req_length = '0;
        rsp_ch.ready      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a window of one byte halves to zero: each request is a first request
        set_max_window(MAXW_BITS'(1));
        send_req(OB'(48'h0000_0000_1234), LB'(5));
        send_req(OFF_TOP, LEN_TOP);

        // zero window: requests do nothing
        set_max_window('0);
        send_req('0, '0);
        send_req(OFF_TOP, LEN_TOP);

        // reset size: first request, ahead prefetch, promotion, saturation
        set_max_window(MAXW_RESET);
        send_req('0, LB'(4096));
        send_req('0, LB'(4096));
        send_req(OB'(4096), LB'(24'h00_F000));
        send_req(OB'(65536), LB'(4096));
        send_req(OB'(65536), LB'(24'h08_0000));
        send_req(OFF_TOP - OB'(100), '0);
        send_req(OFF_TOP - OB'(100), LEN_TOP);
        send_req(OFF_TOP, LEN_TOP);
        send_req(OFF_TOP, '0);

        // largest window, alternating bit patterns
        set_max_window(MAXW_TOP);
        send_req(OB'(48'h5555_5555_5555), '0);
        send_req(OB'(48'h5555_5555_5555), LB'(24'hAA_AAAA));
        send_req(stream_pos, LB'(24'h55_5555));
        send_req(OB'(48'hAAAA_AAAA_AAAA), '0);
        send_req(stream_pos, LB'(24'h00_1000));

        // random phases under changing window sizes
        while (live_items < 560) begin
            case ($urandom_range(0, 6))
                0:       new_maxw = MAXW_TOP;
                1:       new_maxw = MAXW_RESET;
                2:       new_maxw = MAXW_BITS'($urandom_range(16, 4096));
                3:       new_maxw = '0;
                default: new_maxw = MAXW_BITS'($urandom_range(1, 24'hFF_FFFF));
            endcase
            set_max_window(new_maxw);
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            random_stream(new_maxw == 0 ? 8 : 45);
        end

        // closing stretch at full rate, ending with read-ahead switched off
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_max_window(MAXW_TOP);
        random_stream(40);
        send_req(stream_pos ^ OB'(48'h8000_0000_0000), LEN_TOP);
        send_req(stream_pos ^ OB'(48'h8000_0000_0000), LEN_TOP);
        random_stream(4);
        drain();

        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS file_readahead_window_unit");
        end else begin
            $display("FAIL file_readahead_window_unit");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("FAIL file_readahead_window_unit");
        $finish;
    end

endmodule
